// ===== design/cke_pkg.sv =====
// cke_pkg: shared types and constants for the canonical k-mer encoder
// no dependencies
`timescale 1ns / 1ps

package cke_pkg;

   localparam int unsigned MAX_K     = 32;
   localparam int unsigned CODE_W    = 64;
   localparam int unsigned K_W       = 6;
   localparam int unsigned CHAR_W    = 8;

   localparam logic [K_W-1:0] K_RESET = 6'd31;
   localparam logic [K_W-1:0] K_MIN   = 6'd1;
   localparam logic [K_W-1:0] K_MAX   = K_W'(MAX_K);

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [1:0] code;
   } base_type;

   typedef struct packed {
      logic [CODE_W-1:0] forward_code;
      logic [CODE_W-1:0] revcomp_code;
      logic [CODE_W-1:0] canonical_code;
      logic              canonical_is_reverse;
      logic              kmer_ready;
   } result_type;

endpackage

// ===== design/cke_base_decode.sv =====
// cke_base_decode: maps an ascii nucleotide to its 2-bit code and a valid flag
// depends on cke_pkg
`timescale 1ns / 1ps

module cke_base_decode (
   input  logic [cke_pkg::CHAR_W-1:0] base_char,
   output cke_pkg::base_type          base
);
   import cke_pkg::*;

   always_comb begin
      base.valid = 1'b1;
      base.code  = BASE_A;
      unique case (base_char)
         8'h41, 8'h61: base.code = BASE_A;
         8'h43, 8'h63: base.code = BASE_C;
         8'h47, 8'h67: base.code = BASE_G;
         8'h54, 8'h74: base.code = BASE_T;
         default: begin
            base.valid = 1'b0;
            base.code  = BASE_A;
         end
      endcase
   end

endmodule

// ===== design/cke_window.sv =====
// cke_window: k-mer length register, rolling forward and reverse-complement
// windows, run counter and canonical select; depends on cke_pkg
`timescale 1ns / 1ps

module cke_window (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [cke_pkg::K_W-1:0]   csr_wr_data,
   input  logic                      step,
   input  cke_pkg::base_type         base,
   input  logic                      end_of_sequence,
   output cke_pkg::result_type       result
);
   import cke_pkg::*;

   logic [K_W-1:0]    kmer_length_ff;
   logic [CODE_W-1:0] forward_ff, forward_in;
   logic [CODE_W-1:0] revcomp_ff, revcomp_in;
   logic [K_W-1:0]    run_ff, run_in;

   logic [K_W-1:0]    eff_k;
   logic [6:0]        width_bits;
   logic [6:0]        top_bit;
   logic [CODE_W-1:0] fwd_mask;
   logic [CODE_W-1:0] rev_mask;

   always_comb begin
      eff_k = kmer_length_ff;
      if (kmer_length_ff < K_MIN) eff_k = K_MIN;
      if (kmer_length_ff > K_MAX) eff_k = K_MAX;
      width_bits = {eff_k, 1'b0};
      top_bit    = width_bits - 7'd2;
      if (width_bits >= 7'd64) begin
         fwd_mask = '1;
      end else begin
         fwd_mask = (64'd1 << width_bits[5:0]) - 64'd1;
      end
      rev_mask = (64'd1 << top_bit[5:0]) - 64'd1;
   end

   always_comb begin
      forward_in = '0;
      revcomp_in = '0;
      run_in     = '0;
      if (base.valid) begin
         forward_in = ({forward_ff[CODE_W-3:0], base.code}) & fwd_mask;
         revcomp_in = ((revcomp_ff >> 2) & rev_mask)
                    | ({62'd0, ~base.code} << top_bit[5:0]);
         run_in     = (run_ff < eff_k) ? run_ff + 6'd1 : run_ff;
      end
      result.forward_code = forward_in;
      result.revcomp_code = revcomp_in;
      result.kmer_ready   = base.valid && (run_in >= eff_k);
      if (revcomp_in < forward_in) begin
         result.canonical_code       = revcomp_in;
         result.canonical_is_reverse = 1'b1;
      end else begin
         result.canonical_code       = forward_in;
         result.canonical_is_reverse = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff <= K_RESET;
         forward_ff     <= '0;
         revcomp_ff     <= '0;
         run_ff         <= '0;
      end else if (csr_wr_en) begin
         kmer_length_ff <= csr_wr_data;
         forward_ff     <= '0;
         revcomp_ff     <= '0;
         run_ff         <= '0;
      end else if (step) begin
         if (end_of_sequence) begin
            forward_ff <= '0;
            revcomp_ff <= '0;
            run_ff     <= '0;
         end else begin
            forward_ff <= forward_in;
            revcomp_ff <= revcomp_in;
            run_ff     <= run_in;
         end
      end
   end

endmodule

// ===== design/canonical_kmer_encoder.sv =====
// canonical_kmer_encoder: top level with input register, window logic and
// result register; depends on cke_pkg, cke_base_decode, cke_window
// a base goes through the input register, then the result register
// throughput: one base per cycle if rsp_ready is high, set by the window update
// a pending result does not block input while the input register can move on
// reset: synchronous active high, k-mer length to 31, windows and run cleared
`timescale 1ns / 1ps

module canonical_kmer_encoder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [cke_pkg::K_W-1:0]      csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [cke_pkg::CHAR_W-1:0]   req_base_char,
   input  logic                         req_end_of_sequence,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cke_pkg::CODE_W-1:0]   rsp_forward_code,
   output logic [cke_pkg::CODE_W-1:0]   rsp_revcomp_code,
   output logic [cke_pkg::CODE_W-1:0]   rsp_canonical_code,
   output logic                         rsp_canonical_is_reverse,
   output logic                         rsp_kmer_ready,
   output logic                         rsp_sequence_end
);
   import cke_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_eos_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;
   logic              rsp_eos_ff;
   logic              advance;
   logic              req_take;
   base_type          base;
   result_type        result;

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign req_take    = req_valid && req_ready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   cke_base_decode u_decode (
      .base_char (in_char_ff),
      .base      (base)
   );

   cke_window u_window (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .step            (advance),
      .base            (base),
      .end_of_sequence (in_eos_ff),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_base_char;
         in_eos_ff  <= req_end_of_sequence;
      end
      if (advance) begin
         rsp_data_ff <= result;
         rsp_eos_ff  <= in_eos_ff;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_forward_code         = rsp_data_ff.forward_code;
   assign rsp_revcomp_code         = rsp_data_ff.revcomp_code;
   assign rsp_canonical_code       = rsp_data_ff.canonical_code;
   assign rsp_canonical_is_reverse = rsp_data_ff.canonical_is_reverse;
   assign rsp_kmer_ready           = rsp_data_ff.kmer_ready;
   assign rsp_sequence_end         = rsp_eos_ff;

endmodule

// ===== bench/kmer_checker.sv =====
// kmer_checker: watches both channels of the canonical k-mer encoder, rolls its own
// forward and reverse-complement windows and compares every result in order
// depends on cke_pkg
`timescale 1ns / 1ps

module kmer_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [cke_pkg::K_W-1:0]      csr_wr_data,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [cke_pkg::CHAR_W-1:0]   req_base_char,
   input  logic                         req_end_of_sequence,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [cke_pkg::CODE_W-1:0]   rsp_forward_code,
   input  logic [cke_pkg::CODE_W-1:0]   rsp_revcomp_code,
   input  logic [cke_pkg::CODE_W-1:0]   rsp_canonical_code,
   input  logic                         rsp_canonical_is_reverse,
   input  logic                         rsp_kmer_ready,
   input  logic                         rsp_sequence_end,
   output int                           failures,
   output int                           pending_count
);
   import cke_pkg::*;

   typedef struct packed {
      logic [CODE_W-1:0] forward_code;
      logic [CODE_W-1:0] revcomp_code;
      logic [CODE_W-1:0] canonical_code;
      logic              canonical_is_reverse;
      logic              kmer_ready;
      logic              sequence_end;
   } kmer_result_type;

   logic [K_W-1:0]    k_setting;
   logic [CODE_W-1:0] fwd_window;
   logic [CODE_W-1:0] rc_window;
   logic [K_W-1:0]    run_length;
   kmer_result_type   expected_kmers[$];

   function automatic int unsigned window_bases();
      if (k_setting < K_MIN) return 1;
      if (k_setting > K_MAX) return MAX_K;
      return k_setting;
   endfunction

   function automatic logic [CODE_W-1:0] bit_mask(input int unsigned nbits);
      if (nbits >= CODE_W) return '1;
      return (64'd1 << nbits) - 64'd1;
   endfunction

   function automatic void clear_windows();
      fwd_window = '0;
      rc_window  = '0;
      run_length = '0;
   endfunction

   function automatic kmer_result_type roll_window(input logic [CHAR_W-1:0] ch,
                                                   input logic last);
      kmer_result_type r;
      int unsigned     k;
      int unsigned     top;
      logic [1:0]      code;
      logic            is_base;
      k = window_bases();
      top = 2 * k - 2;
      is_base = 1'b1;
      code = BASE_A;
      case (ch)
         "A", "a": code = BASE_A;
         "C", "c": code = BASE_C;
         "G", "g": code = BASE_G;
         "T", "t": code = BASE_T;
         default:  is_base = 1'b0;
      endcase
      r.kmer_ready = 1'b0;
      if (!is_base) begin
         clear_windows();
      end else begin
         fwd_window = ((fwd_window << 2) | CODE_W'(code)) & bit_mask(2 * k);
         rc_window = ((rc_window >> 2) & bit_mask(top)) | (CODE_W'(BASE_T - code) << top);
         if (run_length < k) run_length++;
         r.kmer_ready = (run_length >= k);
      end
      r.forward_code = fwd_window;
      r.revcomp_code = rc_window;
      r.canonical_is_reverse = (rc_window < fwd_window);
      r.canonical_code = r.canonical_is_reverse ? rc_window : fwd_window;
      r.sequence_end = last;
      if (last) clear_windows();
      return r;
   endfunction

   function automatic void check_field(input string label, input logic [CODE_W-1:0] want,
                                       input logic [CODE_W-1:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t mismatch %s expected %h actual %h", $time, label, want, got);
      end
   endfunction

   always @(posedge clock) begin : monitor
      kmer_result_type want;
      if (reset) begin
         k_setting = K_RESET;
         clear_windows();
         expected_kmers.delete();
         failures = 0;
      end else begin
         if (csr_wr_en) begin
            k_setting = csr_wr_data;
            clear_windows();
         end
         if (req_valid && req_ready)
            expected_kmers.push_back(roll_window(req_base_char, req_end_of_sequence));
         if (rsp_valid && rsp_ready) begin
            if (expected_kmers.size() == 0) begin
               failures++;
               $display("%0t unexpected transaction expected none actual fwd %h",
                        $time, rsp_forward_code);
            end else begin
               want = expected_kmers.pop_front();
               check_field("forward_code", want.forward_code, rsp_forward_code);
               check_field("revcomp_code", want.revcomp_code, rsp_revcomp_code);
               check_field("canonical_code", want.canonical_code, rsp_canonical_code);
               check_field("canonical_is_reverse", 64'(want.canonical_is_reverse),
                           64'(rsp_canonical_is_reverse));
               check_field("kmer_ready", 64'(want.kmer_ready), 64'(rsp_kmer_ready));
               check_field("sequence_end", 64'(want.sequence_end), 64'(rsp_sequence_end));
            end
         end
      end
      pending_count = expected_kmers.size();
   end

endmodule

// ===== bench/tb.sv =====
// tb: drives bases and k-mer length writes into the canonical k-mer encoder
// under varying backpressure and gives the verdict; depends on cke_pkg,
// canonical_kmer_encoder and kmer_checker
`timescale 1ns / 1ps

module tb;
   import cke_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int RANDOM_PER_PHASE = 200;
   localparam int HOLD_OFF_CYCLES  = 80;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [K_W-1:0]    csr_wr_data;
   logic              req_valid;
   logic              req_ready;
   logic [CHAR_W-1:0] req_base_char;
   logic              req_end_of_sequence;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CODE_W-1:0] rsp_forward_code;
   logic [CODE_W-1:0] rsp_revcomp_code;
   logic [CODE_W-1:0] rsp_canonical_code;
   logic              rsp_canonical_is_reverse;
   logic              rsp_kmer_ready;
   logic              rsp_sequence_end;
   int                failures;
   int                pending_count;

   int send_idle;
   int recv_idle;
   bit hold_arm;
   bit hold_used;
   int hold_left;

   canonical_kmer_encoder dut (.*);

   kmer_checker u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver, with one long hold-off once armed
   always @(negedge clock) begin
      if (hold_arm && !hold_used) begin
         hold_used = 1'b1;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_base(input logic [CHAR_W-1:0] ch, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_base_char <= ch;
      req_end_of_sequence <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_k(input logic [K_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CHAR_W-1:0] pick_base();
      case ($urandom_range(7))
         0: return "A";
         1: return "C";
         2: return "G";
         3: return "T";
         4: return "a";
         5: return "c";
         6: return "g";
         default: return "t";
      endcase
   endfunction

   // mostly clean reads of random length, some junk reads and stray breaks
   task automatic run_reads(input int count);
      int                sent;
      int                len;
      int                i;
      int                roll;
      bit                junk;
      logic [CHAR_W-1:0] ch;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(90, 1);
         junk = ($urandom_range(99) < 10);
         for (i = 0; i < len && sent < count; i++) begin
            roll = $urandom_range(99);
            if (junk) ch = CHAR_W'($urandom_range(255));
            else if (roll < 2) ch = $urandom_range(1) ? "N" : "n";
            else if (roll < 3) ch = CHAR_W'($urandom_range(255));
            else ch = pick_base();
            send_base(ch, (i == len - 1) || (junk && roll < 5));
            sent++;
         end
      end
   endtask

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int             phase;
      logic [K_W-1:0] k_value;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_base_char = '0;
      req_end_of_sequence = 1'b0;
      send_idle = 13;
      recv_idle = 69;
      hold_arm = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset length, break, end of sequence
      send_base("A", 1'b0);
      send_base("T", 1'b0);
      send_base("N", 1'b0);
      send_base("G", 1'b1);

      write_k(6'd3);
      send_base("A", 1'b0);
      send_base("C", 1'b0);
      send_base("G", 1'b0);
      send_base("T", 1'b0);
      send_base("a", 1'b0);
      send_base("c", 1'b0);
      send_base("g", 1'b0);
      send_base("t", 1'b0);
      send_base("N", 1'b0);
      send_base("n", 1'b0);
      send_base(8'h00, 1'b0);
      send_base(8'hFF, 1'b0);
      send_base("T", 1'b0);
      send_base("T", 1'b0);
      send_base("T", 1'b1);
      send_base("x", 1'b1);
      send_base("A", 1'b0);

      // palindrome gives a tie, forward wins
      write_k(6'd2);
      send_base("A", 1'b0);
      send_base("T", 1'b0);
      send_base("G", 1'b0);
      send_base("C", 1'b1);

      for (phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               send_idle = 13;
               recv_idle = 69;
            end
            1: begin
               send_idle = 69;
               recv_idle = 13;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         case (phase)
            0: k_value = K_MIN;
            1: k_value = K_MAX;
            2: k_value = 6'd0;
            3: k_value = 6'd63;
            4: k_value = K_W'($urandom_range(31, 2));
            default: k_value = K_W'($urandom_range(63));
         endcase
         write_k(k_value);
         if (phase == 5) hold_arm = 1'b1;
         run_reads(RANDOM_PER_PHASE);
      end

      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (failures == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
